// ===== rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants for the tile plane pixel compositor.
// ----------------------------------------------------------------------------
package tpc_pkg;

  // default store sizes
  localparam int VRAM_WORDS_DEF  = 32768;
  localparam int PALETTE_ENTRIES = 64;

  // request codes
  typedef enum logic [1:0] {
    OP_VRAM_WRITE    = 2'd0,
    OP_PALETTE_WRITE = 2'd1,
    OP_RENDER        = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [2:0] CFG_PLANE_A_BASE  = 3'd0;
  localparam logic [2:0] CFG_PLANE_B_BASE  = 3'd1;
  localparam logic [2:0] CFG_HSCROLL_BASE  = 3'd2;
  localparam logic [2:0] CFG_HSCROLL_MODE  = 3'd3;
  localparam logic [2:0] CFG_PLANE_SIZE    = 3'd4;
  localparam logic [2:0] CFG_VSCROLL_A     = 3'd5;
  localparam logic [2:0] CFG_VSCROLL_B     = 3'd6;
  localparam logic [2:0] CFG_BACKDROP      = 3'd7;

  // horizontal scroll modes
  localparam logic [1:0] HS_WHOLE  = 2'd0;
  localparam logic [1:0] HS_CELL4  = 2'd1;
  localparam logic [1:0] HS_CELL16 = 2'd2;
  localparam logic [1:0] HS_LINE   = 2'd3;

  // source layer codes
  localparam logic [2:0] LAYER_BACKDROP = 3'd0;
  localparam logic [2:0] LAYER_B_LOW    = 3'd1;
  localparam logic [2:0] LAYER_A_LOW    = 3'd2;
  localparam logic [2:0] LAYER_B_HIGH   = 3'd3;
  localparam logic [2:0] LAYER_A_HIGH   = 3'd4;

  // video memory port 0 request
  typedef struct packed {
    logic        wr;
    logic [14:0] addr;
    logic [15:0] wdata;
  } vram_req_t;

  // palette write request
  typedef struct packed {
    logic        wr;
    logic [5:0]  addr;
    logic [23:0] color;
  } pal_wr_t;

endpackage

// ===== rtl/tpc_vram.sv =====
// ----------------------------------------------------------------------------
// tpc_vram
// Video memory: one read/write port, one read port, registered read data,
// zero sweep over every word after reset.
// ----------------------------------------------------------------------------
module tpc_vram #(
  parameter int VRAM_WORDS = tpc_pkg::VRAM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tpc_pkg::vram_req_t port0_req,
  input  logic [14:0]       port1_addr,
  output logic [15:0]       port0_rdata,
  output logic [15:0]       port1_rdata,
  output logic              clearing
);

  localparam int AW = $clog2(VRAM_WORDS);

  logic [15:0]   mem [VRAM_WORDS];
  logic [AW-1:0] clr_addr;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(VRAM_WORDS - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // port 0, read before write
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (port0_req.wr) begin
      mem[port0_req.addr[AW-1:0]] <= port0_req.wdata;
    end
    port0_rdata <= mem[port0_req.addr[AW-1:0]];
  end

  // port 1
  always_ff @(posedge clk) begin
    port1_rdata <= mem[port1_addr[AW-1:0]];
  end

endmodule

// ===== rtl/tpc_palette.sv =====
// ----------------------------------------------------------------------------
// tpc_palette
// Color table with one write and one registered read; per-entry valid bits
// make unwritten entries read as black.
// ----------------------------------------------------------------------------
module tpc_palette (
  input  logic             clk,
  input  logic             rst,
  input  tpc_pkg::pal_wr_t wr,
  input  logic [5:0]       rd_addr,
  output logic [23:0]      rd_color
);

  logic [23:0]                         mem [tpc_pkg::PALETTE_ENTRIES];
  logic [tpc_pkg::PALETTE_ENTRIES-1:0] valid;
  logic                                valid_q;
  logic [23:0]                         data_q;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.wr) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // storage, old data on a same-entry read
  always_ff @(posedge clk) begin
    if (wr.wr) mem[wr.addr] <= wr.color;
    data_q  <= mem[rd_addr];
    valid_q <= valid[rd_addr];
  end

  assign rd_color = valid_q ? data_q : '0;

endmodule

// ===== rtl/tile_plane_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// tile_plane_pixel_compositor
// Two-plane tile map pixel renderer with palette lookup.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken when start is high and busy is low. operation
//   selects a video memory word write, a palette write or a pixel render.
//   Writes return nothing. A render returns one result: result_valid is
//   high for one cycle once the request has passed stages v1 to v4,
//   carrying color_rgb, pal_index and source_layer. The receiver has no
//   way to stall, and none is needed.
//   Each render makes three dependent reads on each of the two video memory
//   ports (scroll entry, name table word, pattern word), one per plane,
//   so busy stays high while the render is in stages v1 and v2: a new
//   render is not taken until the last of those reads is issued, and writes
//   run at one per cycle while busy is low; results overlap the next requests.
//   Configuration writes use cfg_valid/cfg_ready (always ready); the user
//   must make them only while no render is in flight; the block does not
//   enforce this. After reset, busy stays high while every video memory
//   word is swept to zero; the palette clears at once.
// ----------------------------------------------------------------------------
module tile_plane_pixel_compositor #(
  parameter int VRAM_WORDS = tpc_pkg::VRAM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [14:0] address,
  input  logic [23:0] data,
  input  logic [8:0]  pixel_x,
  input  logic [8:0]  pixel_y,
  output logic        result_valid,
  output logic [23:0] color_rgb,
  output logic [5:0]  pal_index,
  output logic [2:0]  source_layer,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  // configuration registers
  logic [2:0] plane_a_base, plane_b_base;
  logic [5:0] hscroll_table_base;
  logic [1:0] hscroll_mode, plane_size;
  logic [9:0] vertical_scroll_a, vertical_scroll_b;
  logic [5:0] backdrop_index;

  // pipeline control
  logic clearing, acc, rnd_acc, vram_wr_acc, pal_wr_acc;
  logic v1, v2, v3, v4;

  // memory ports
  tpc_pkg::vram_req_t port0_req;
  tpc_pkg::pal_wr_t   pal_wr;
  logic [14:0] port1_addr;
  logic [15:0] rdata_raw [2];
  logic [15:0] rd [2];
  logic [15:0] word_sel [2];
  logic [1:0]  oob_q;

  // per plane stage values
  logic [9:0]  line_idx;
  logic [15:0] hs_word [2];
  logic [15:0] name_word [2];
  logic [15:0] pat_word [2];
  logic [2:0]  base_p [2];
  logic [9:0]  vs_p [2];
  logic [8:0]  h [2], px [2], py [2];
  logic [9:0]  py_sum [2];
  logic [11:0] ty_off [2];
  logic [2:0]  fx [2], fy [2];
  logic [7:0]  pbyte [2];
  logic [3:0]  pix [2];
  logic [1:0]  opaque, prio;
  logic [5:0]  idx [2];

  // stage registers
  logic [8:0]  s1_x, s1_y;
  logic [2:0]  s2_px [2], s2_py [2];
  logic [2:0]  s3_hi [2];
  logic [1:0]  s3_fx [2];
  logic [5:0]  pick_idx;
  logic [2:0]  pick_layer;
  logic [2:0]  s4_layer;
  logic [5:0]  s4_idx;

  assign busy        = clearing | v1 | v2;
  assign acc         = start & ~busy;
  assign rnd_acc     = acc & (operation == tpc_pkg::OP_RENDER);
  assign vram_wr_acc = acc & (operation == tpc_pkg::OP_VRAM_WRITE)
                       & ({1'b0, address} < 16'(VRAM_WORDS));
  assign pal_wr_acc  = acc & (operation == tpc_pkg::OP_PALETTE_WRITE)
                       & (address[14:6] == '0);
  assign cfg_ready   = 1'b1;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_a_base       <= '0;
      plane_b_base       <= '0;
      hscroll_table_base <= '0;
      hscroll_mode       <= '0;
      plane_size         <= '0;
      vertical_scroll_a  <= '0;
      vertical_scroll_b  <= '0;
      backdrop_index     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpc_pkg::CFG_PLANE_A_BASE: plane_a_base       <= cfg_data[2:0];
        tpc_pkg::CFG_PLANE_B_BASE: plane_b_base       <= cfg_data[2:0];
        tpc_pkg::CFG_HSCROLL_BASE: hscroll_table_base <= cfg_data[5:0];
        tpc_pkg::CFG_HSCROLL_MODE: hscroll_mode       <= cfg_data[1:0];
        tpc_pkg::CFG_PLANE_SIZE:   plane_size         <= cfg_data[1:0];
        tpc_pkg::CFG_VSCROLL_A:    vertical_scroll_a  <= cfg_data;
        tpc_pkg::CFG_VSCROLL_B:    vertical_scroll_b  <= cfg_data;
        tpc_pkg::CFG_BACKDROP:     backdrop_index     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign base_p[0] = plane_a_base;
  assign base_p[1] = plane_b_base;
  assign vs_p[0]   = vertical_scroll_a;
  assign vs_p[1]   = vertical_scroll_b;

  // scroll table row for this line
  always_comb begin
    case (hscroll_mode)
      tpc_pkg::HS_CELL4:  line_idx = {2'b0, pixel_y[8:3], 2'b0};
      tpc_pkg::HS_CELL16: line_idx = {pixel_y[8:3], 4'b0};
      tpc_pkg::HS_LINE:   line_idx = {pixel_y, 1'b0};
      default:            line_idx = '0;
    endcase
  end

  // per plane address and pixel logic
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      rd[p]      = oob_q[p] ? 16'h0 : rdata_raw[p];
      hs_word[p] = {1'b0, hscroll_table_base, 9'b0} + 16'(line_idx) + 16'(p);
      // scroll entry back: plane coordinates
      h[p]       = 9'(16'h0 - rd[p]);
      px[p]      = (s1_x + h[p]) & (plane_size[0] ? 9'h1FF : 9'h0FF);
      py_sum[p]  = {1'b0, s1_y} + vs_p[p];
      py[p]      = py_sum[p][8:0] & (plane_size[1] ? 9'h1FF : 9'h0FF);
      ty_off[p]  = plane_size[0] ? {py[p][8:3], 6'b0} : {1'b0, py[p][8:3], 5'b0};
      name_word[p] = {1'b0, base_p[p], ty_off[p] + {6'b0, px[p][8:3]}};
      // name word back: flips and pattern address
      fx[p]      = rd[p][11] ? ~s2_px[p] : s2_px[p];
      fy[p]      = rd[p][12] ? ~s2_py[p] : s2_py[p];
      pat_word[p] = {1'b0, rd[p][10:0], fy[p], fx[p][2]};
      // pattern word back: pixel value
      pbyte[p]   = s3_fx[p][1] ? rd[p][7:0] : rd[p][15:8];
      pix[p]     = s3_fx[p][0] ? pbyte[p][3:0] : pbyte[p][7:4];
      opaque[p]  = pix[p] != 4'h0;
      prio[p]    = s3_hi[p][2];
      idx[p]     = {s3_hi[p][1:0], pix[p]};
    end
  end

  // port address select
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (p == 0 && vram_wr_acc) word_sel[p] = {1'b0, address};
      else if (v1)               word_sel[p] = name_word[p];
      else if (v2)               word_sel[p] = pat_word[p];
      else                       word_sel[p] = hs_word[p];
    end
    port0_req.wr    = vram_wr_acc;
    port0_req.addr  = word_sel[0][14:0];
    port0_req.wdata = data[15:0];
    port1_addr      = word_sel[1][14:0];
  end

  // out of range reads return zero
  always_ff @(posedge clk) begin
    for (int p = 0; p < 2; p++) begin
      oob_q[p] <= word_sel[p] >= 16'(VRAM_WORDS);
    end
  end

  // layer precedence
  always_comb begin
    if (opaque[0] && prio[0]) begin
      pick_idx = idx[0]; pick_layer = tpc_pkg::LAYER_A_HIGH;
    end else if (opaque[1] && prio[1]) begin
      pick_idx = idx[1]; pick_layer = tpc_pkg::LAYER_B_HIGH;
    end else if (opaque[0]) begin
      pick_idx = idx[0]; pick_layer = tpc_pkg::LAYER_A_LOW;
    end else if (opaque[1]) begin
      pick_idx = idx[1]; pick_layer = tpc_pkg::LAYER_B_LOW;
    end else begin
      pick_idx = backdrop_index; pick_layer = tpc_pkg::LAYER_BACKDROP;
    end
  end

  // stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= rnd_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (rnd_acc) begin
      s1_x <= pixel_x;
      s1_y <= pixel_y;
    end
    for (int p = 0; p < 2; p++) begin
      if (v1) begin
        s2_px[p] <= px[p][2:0];
        s2_py[p] <= py[p][2:0];
      end
      if (v2) begin
        s3_hi[p] <= rd[p][15:13];
        s3_fx[p] <= fx[p][1:0];
      end
    end
    if (v3) begin
      s4_idx   <= pick_idx;
      s4_layer <= pick_layer;
    end
  end

  assign pal_wr.wr    = pal_wr_acc;
  assign pal_wr.addr  = address[5:0];
  assign pal_wr.color = data;

  tpc_vram #(.VRAM_WORDS(VRAM_WORDS)) u_vram (
    .clk        (clk),
    .rst        (rst),
    .port0_req  (port0_req),
    .port1_addr (port1_addr),
    .port0_rdata(rdata_raw[0]),
    .port1_rdata(rdata_raw[1]),
    .clearing   (clearing)
  );

  tpc_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr      (pal_wr),
    .rd_addr (pick_idx),
    .rd_color(color_rgb)
  );

  assign result_valid  = v4;
  assign pal_index     = s4_idx;
  assign source_layer  = s4_layer;

  // render beat is always followed by a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    rnd_acc |-> ##4 result_valid) else $error("render result missing");

  // no result without a render beat
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(rnd_acc, 4)) else $error("spurious result");

  // memory port stages never overlap
  a_stage_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({v1, v2, v3})) else $error("port stages overlap");

  // no request while memory sweep runs
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !acc) else $error("request during clear");

endmodule

// ===== tb/tile_plane_pixel_compositor_tb.sv =====
// ----------------------------------------------------------------------------
// tile_plane_pixel_compositor_tb
// Self-checking bench for the two-plane tile compositor. A directed table and
// random traffic (video memory writes, palette writes, renders and the unused
// code) are sent under several register settings; every render result is
// checked field by field against a local model of scroll, wrap, flip and
// plane priority, or against the fixed value of a typed directed row.
// ----------------------------------------------------------------------------
module tile_plane_pixel_compositor_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STORE_BYTES = 2 * tpc_pkg::VRAM_WORDS_DEF;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 42;

  typedef struct packed {
    logic [23:0] rgb;
    logic [5:0]  index;
    logic [2:0]  layer;
  } pixel_t;

  typedef struct {
    logic [1:0]  op;
    logic [14:0] addr;
    logic [23:0] data;
    logic [8:0]  x;
    logic [8:0]  y;
    bit          typed;
    pixel_t      pix;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = tpc_pkg::OP_VRAM_WRITE;
  logic [14:0] address = '0;
  logic [23:0] data = '0;
  logic [8:0]  pixel_x = '0;
  logic [8:0]  pixel_y = '0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        busy, result_valid, cfg_ready;
  logic [23:0] color_rgb;
  logic [5:0]  pal_index;
  logic [2:0]  source_layer;

  // shadow of the block state
  logic [15:0] vram_copy [tpc_pkg::VRAM_WORDS_DEF];
  logic [23:0] palette_copy [tpc_pkg::PALETTE_ENTRIES];
  int a_base, b_base, hs_base, hs_mode, psize, vs_a, vs_b, backdrop;

  pixel_t pending_pixels [$];
  int idle_pct = 0;
  int n_renders = 0, n_writes = 0, n_checked = 0, n_errors = 0;

  tile_plane_pixel_compositor uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .address(address), .data(data),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .result_valid(result_valid), .color_rgb(color_rgb),
    .pal_index(pal_index), .source_layer(source_layer),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int vram_byte(input int a);
    logic [15:0] w;
    if (a >= STORE_BYTES) return 0;
    w = vram_copy[a >> 1];
    return (a & 1) ? int'(w[7:0]) : int'(w[15:8]);
  endfunction

  function automatic int vram_word(input int a);
    return (vram_byte(a) << 8) | vram_byte(a + 1);
  endfunction

  function automatic int scroll_addr(input int hoff, input int sy);
    int li;
    case (hs_mode)
      tpc_pkg::HS_CELL4:  li = (sy >> 3) * 4;
      tpc_pkg::HS_CELL16: li = (sy >> 3) * 16;
      tpc_pkg::HS_LINE:   li = sy * 2;
      default:            li = 0;
    endcase
    return hs_base * 'h400 + (li + hoff) * 2;
  endfunction

  // one plane: low 6 bits pixel, bit 6 opaque, bit 7 priority
  function automatic int plane_fetch(input int base, input int hoff, input int vs,
                                     input int sx, input int sy,
                                     output int tw_addr, output int pat_addr);
    int wt, ht, h, px, py, tw, tx, ty, b, pix, prio;
    wt = psize[0] ? 64 : 32;
    ht = psize[1] ? 64 : 32;
    h = (-vram_word(scroll_addr(hoff, sy))) & 'h1FF;
    px = (sx + h) & (wt * 8 - 1);
    py = (sy + vs) & (ht * 8 - 1);
    tw_addr = base * 'h2000 + ((py >> 3) * wt + (px >> 3)) * 2;
    tw = vram_word(tw_addr);
    tx = (tw & 'h0800) ? 7 - (px & 7) : (px & 7);
    ty = (tw & 'h1000) ? 7 - (py & 7) : (py & 7);
    pat_addr = (tw & 'h07FF) * 32 + ty * 4 + (tx >> 1);
    b = vram_byte(pat_addr);
    pix = (tx & 1) ? (b & 'h0F) : (b >> 4);
    prio = (tw & 'h8000) ? 'h80 : 0;
    if (pix == 0) return prio;
    return (((tw >> 13) & 3) * 16 + pix) | 'h40 | prio;
  endfunction

  function automatic pixel_t composite_pixel(input int sx, input int sy);
    int a, b, ta, pa;
    pixel_t p;
    a = plane_fetch(a_base, 0, vs_a, sx, sy, ta, pa);
    b = plane_fetch(b_base, 1, vs_b, sx, sy, ta, pa);
    if ((a & 'hC0) == 'hC0) begin
      p.index = a[5:0]; p.layer = tpc_pkg::LAYER_A_HIGH;
    end else if ((b & 'hC0) == 'hC0) begin
      p.index = b[5:0]; p.layer = tpc_pkg::LAYER_B_HIGH;
    end else if ((a & 'hC0) == 'h40) begin
      p.index = a[5:0]; p.layer = tpc_pkg::LAYER_A_LOW;
    end else if ((b & 'hC0) == 'h40) begin
      p.index = b[5:0]; p.layer = tpc_pkg::LAYER_B_LOW;
    end else begin
      p.index = backdrop[5:0]; p.layer = tpc_pkg::LAYER_BACKDROP;
    end
    p.rgb = palette_copy[p.index];
    return p;
  endfunction

  // send one request beat, optionally with a typed expectation
  task automatic send(input logic [1:0] op, input logic [14:0] ad, input logic [23:0] dt,
                      input logic [8:0] x, input logic [8:0] y,
                      input bit typed = 1'b0, input pixel_t known = '0);
    pixel_t exp_pix;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    address <= ad;
    data <= dt;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (busy);
    case (op)
      tpc_pkg::OP_VRAM_WRITE: begin
        vram_copy[ad] = dt[15:0];
        n_writes++;
      end
      tpc_pkg::OP_PALETTE_WRITE: begin
        if (ad < tpc_pkg::PALETTE_ENTRIES) palette_copy[ad] = dt;
        n_writes++;
      end
      tpc_pkg::OP_RENDER: begin
        exp_pix = typed ? known : composite_pixel(x, y);
        pending_pixels = {pending_pixels, exp_pix};
        n_renders++;
      end
      default: ;
    endcase
  endtask

  // one register beat; the caller drops cfg_valid after the last one
  task automatic cfg_write(input logic [2:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[9:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tpc_pkg::CFG_PLANE_A_BASE: a_base = val & 7;
      tpc_pkg::CFG_PLANE_B_BASE: b_base = val & 7;
      tpc_pkg::CFG_HSCROLL_BASE: hs_base = val & 'h3F;
      tpc_pkg::CFG_HSCROLL_MODE: hs_mode = val & 3;
      tpc_pkg::CFG_PLANE_SIZE:   psize = val & 3;
      tpc_pkg::CFG_VSCROLL_A:    vs_a = val & 'h3FF;
      tpc_pkg::CFG_VSCROLL_B:    vs_b = val & 'h3FF;
      default:                   backdrop = val & 'h3F;
    endcase
  endtask

  // let outstanding renders finish, then idle so the pipeline empties
  task automatic drain();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // set up name table and pattern (and at times the scroll entry) under a pixel, then render it
  task automatic pixel_sequence();
    int x, y, ta, pa, r;
    x = $urandom_range(511);
    y = $urandom_range(511);
    if ($urandom_range(3) == 0) begin
      r = scroll_addr($urandom_range(1), y);
      if (r < STORE_BYTES)
        send(tpc_pkg::OP_VRAM_WRITE, 15'(r >> 1), 24'($urandom), 9'd0, 9'd0);
    end
    r = plane_fetch(a_base, 0, vs_a, x, y, ta, pa);
    send(tpc_pkg::OP_VRAM_WRITE, 15'(ta >> 1),
         24'({5'($urandom_range(31)), 11'($urandom_range(63))}), 9'd0, 9'd0);
    r = plane_fetch(a_base, 0, vs_a, x, y, ta, pa);
    send(tpc_pkg::OP_VRAM_WRITE, 15'(pa >> 1), 24'($urandom), 9'd0, 9'd0);
    if ($urandom_range(1)) begin
      r = plane_fetch(b_base, 1, vs_b, x, y, ta, pa);
      send(tpc_pkg::OP_VRAM_WRITE, 15'(ta >> 1),
           24'({5'($urandom_range(31)), 11'($urandom_range(63))}), 9'd0, 9'd0);
      r = plane_fetch(b_base, 1, vs_b, x, y, ta, pa);
      send(tpc_pkg::OP_VRAM_WRITE, 15'(pa >> 1), 24'($urandom), 9'd0, 9'd0);
    end
    send(tpc_pkg::OP_RENDER, 15'($urandom), 24'($urandom), 9'(x), 9'(y));
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      pixel_sequence();
    else if (r < 68)
      send(tpc_pkg::OP_RENDER, 15'($urandom), 24'($urandom), 9'($urandom), 9'($urandom));
    else if (r < 80)
      send(tpc_pkg::OP_PALETTE_WRITE,
           15'(($urandom_range(9) == 0) ? $urandom : $urandom_range(63)),
           24'($urandom), 9'($urandom), 9'($urandom));
    else if (r < 96)
      send(tpc_pkg::OP_VRAM_WRITE, 15'($urandom), 24'($urandom), 9'($urandom),
           9'($urandom));
    else
      send(OP_UNUSED, 15'($urandom), 24'($urandom), 9'($urandom), 9'($urandom));
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && result_valid) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result rgb=%h index=%0d layer=%0d",
                 $time, color_rgb, pal_index, source_layer);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (color_rgb !== want.rgb) begin
          $display("%0t: color_rgb expected %h actual %h", $time, want.rgb, color_rgb);
          n_errors++;
        end
        if (pal_index !== want.index) begin
          $display("%0t: pal_index expected %0d actual %0d",
                   $time, want.index, pal_index);
          n_errors++;
        end
        if (source_layer !== want.layer) begin
          $display("%0t: source_layer expected %0d actual %0d",
                   $time, want.layer, source_layer);
          n_errors++;
        end
      end
    end
  end

  // directed table: reset state, range edges, flips and ignored requests
  stim_row_t directed [] = '{
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd0,   9'd0,   1'b1,
      '{24'h0, 6'd0, tpc_pkg::LAYER_BACKDROP}},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd511, 9'd511, 1'b1,
      '{24'h0, 6'd0, tpc_pkg::LAYER_BACKDROP}},
    '{tpc_pkg::OP_PALETTE_WRITE, 15'd0,    24'hFFFFFF, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_PALETTE_WRITE, 15'd63,   24'h00FF00, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_PALETTE_WRITE, 15'd64,   24'hABCDEF, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_PALETTE_WRITE, 15'h7FFF, 24'h123456, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd0,   9'd0,   1'b1,
      '{24'hFFFFFF, 6'd0, tpc_pkg::LAYER_BACKDROP}},
    '{OP_UNUSED,                 15'h7FFF, 24'hFFFFFF, 9'd511, 9'd511, 1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'h7FFF, 24'hFFFFFF, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'd0,    24'h00E001, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'd16,   24'h00FFFF, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'd17,   24'h001F00, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'd18,   24'h0000F0, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'd31,   24'h0F0F0F, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd7,   9'd7,   1'b0, '0},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd511, 9'd0,   1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'd0,    24'h001801, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd3,   9'd3,   1'b0, '0},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd0,   9'd511, 1'b0, '0},
    '{tpc_pkg::OP_PALETTE_WRITE, 15'd63,   24'h123456, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_VRAM_WRITE,    15'd0,    24'h00F801, 9'd0,   9'd0,   1'b0, '0},
    '{tpc_pkg::OP_RENDER,        15'd0,    24'd0,      9'd100, 9'd200, 1'b0, '0}
  };

  // stimulus
  initial begin
    int idle_plan [PHASES] = '{0, 88, 7, 0, 88, 7, 0, 88};
    for (int i = 0; i < tpc_pkg::VRAM_WORDS_DEF; i++) vram_copy[i] = '0;
    for (int i = 0; i < tpc_pkg::PALETTE_ENTRIES; i++) palette_copy[i] = '0;
    {a_base, b_base, hs_base, hs_mode, psize, vs_a, vs_b, backdrop} = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send(directed[i].op, directed[i].addr, directed[i].data,
           directed[i].x, directed[i].y, directed[i].typed, directed[i].pix);
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      for (int r = 0; r < 8; r++) begin
        int val;
        if (ph == 0) val = 'h3FF;
        else if (ph == 1) val = 0;
        else val = $urandom_range(1023);
        cfg_write(r[2:0], val);
      end
      cfg_valid <= 1'b0;
      idle_pct = idle_plan[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end
    drain();
    $display("covered %0d renders checked of %0d sent, %0d writes, %0d register settings",
             n_checked, n_renders, n_writes, PHASES + 1);
    if (n_errors == 0 && pending_pixels.size() == 0)
      $display("tile_plane_pixel_compositor_tb OK");
    else
      $display("tile_plane_pixel_compositor_tb NOT OK");
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("tile_plane_pixel_compositor_tb NOT OK");
    $finish;
  end

endmodule

// ===== tile_plane_pixel_compositor.f =====
rtl/tpc_pkg.sv
rtl/tpc_vram.sv
rtl/tpc_palette.sv
rtl/tile_plane_pixel_compositor.sv
tb/tile_plane_pixel_compositor_tb.sv
